@@ rtl/ifla_pkg.sv @@
// Shared constants, types and command structs for the index free-list allocator.
package ifla_pkg;

  // Table geometry
  localparam int unsigned CAPACITY = 256;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] NULL_LINK = CNT_W'(CAPACITY);

  // Request kinds
  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NOP   = 2'd3
  } kind_e;

  // Controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_POP  = 1'b1
  } state_e;

  // Result status codes
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_EXHAUSTED = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic rd_head;  // read the head slot's link
    logic pop;      // advance head to the link just read, or to the next index for a never-written slot; emit the beat
    logic push;     // link entry onto head
    logic clear;    // rechain every slot
    logic emit;     // emit a beat that echoes the entry index
    logic exhaust;  // emitted beat is an exhausted allocate
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;
    logic full;
    logic idx_ok;
  } dp_status_t;

endpackage

@@ rtl/ifla_ram.sv @@
// Generic single-port RAM with registered read data.
module ifla_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read first port, read data is registered and lands in the cycle after the address
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ifla_ctrl.sv @@
// Request sequencer: decodes the accepted beat into datapath commands.
module ifla_ctrl import ifla_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  kind_e       kind_i,
  input  dp_status_t  status_i,
  output logic        busy_o,
  output ctrl_cmd_t   cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  // Next state: only a non-empty allocate needs the link read cycle
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (kind_i == KIND_ALLOC) && !status_i.empty) begin
          state_d = ST_POP;
        end
      end
      ST_POP: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Command decode
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (kind_i)
            KIND_ALLOC: begin
              if (status_i.empty) begin
                cmd_o.emit    = 1'b1;
                cmd_o.exhaust = 1'b1;
              end else begin
                cmd_o.rd_head = 1'b1;
              end
            end
            KIND_FREE: begin
              cmd_o.push = status_i.idx_ok && !status_i.full;
              cmd_o.emit = 1'b1;
            end
            KIND_CLEAR: begin
              cmd_o.clear = 1'b1;
              cmd_o.emit  = 1'b1;
            end
            KIND_NOP: cmd_o.emit = 1'b1;
            default:  cmd_o.emit = 1'b1;
          endcase
        end
      end
      ST_POP:  cmd_o.pop = 1'b1;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/ifla_dp.sv @@
// Datapath: head, free count, link memory with per-slot written bits, result register.
module ifla_dp import ifla_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_cmd_t        cmd_i,
  input  logic [IDX_W-1:0] entry_index_i,
  output dp_status_t       status_o,
  output logic             result_valid_o,
  output logic [IDX_W-1:0] slot_index_o,
  output logic             result_status_o,
  output logic [CNT_W-1:0] free_count_o
);

  logic [CNT_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CAPACITY-1:0] written_q;
  logic             written_rd_q;
  logic             ram_we;
  logic [IDX_W-1:0] ram_addr;
  logic [CNT_W-1:0] ram_rdata;
  logic             valid_q;
  logic [IDX_W-1:0] slot_q, slot_d;
  logic             stat_q, stat_d;
  logic [CNT_W-1:0] cnt_out_q;

  // Status toward the controller
  assign status_o.empty  = (count_q == '0) || (head_q >= NULL_LINK);
  assign status_o.full   = (count_q == NULL_LINK);
  assign status_o.idx_ok = ({1'b0, entry_index_i} < NULL_LINK);

  // Link memory: write on push, otherwise read at the head slot
  assign ram_we   = cmd_i.push;
  assign ram_addr = cmd_i.push ? entry_index_i : head_q[IDX_W-1:0];

  ifla_ram #(
    .WIDTH (CNT_W),
    .DEPTH (CAPACITY)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (head_q),
    .rdata_o (ram_rdata)
  );

  // Head and count update; a never-written slot links to the next index
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (cmd_i.clear) begin
      head_d  = '0;
      count_d = NULL_LINK;
    end else if (cmd_i.push) begin
      head_d  = CNT_W'(entry_index_i);
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.pop) begin
      head_d  = written_rd_q ? ram_rdata : (head_q + CNT_W'(1));
      count_d = count_q - CNT_W'(1);
    end
  end

  // Result beat contents
  always_comb begin
    slot_d = entry_index_i;
    stat_d = STATUS_OK;
    if (cmd_i.pop) begin
      slot_d = head_q[IDX_W-1:0];
    end else if (cmd_i.exhaust) begin
      slot_d = '0;
      stat_d = STATUS_EXHAUSTED;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      count_q   <= NULL_LINK;
      written_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      valid_q <= cmd_i.emit || cmd_i.pop;
      if (cmd_i.clear) begin
        written_q <= '0;
      end else if (cmd_i.push) begin
        written_q[entry_index_i] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_head) begin
      written_rd_q <= written_q[head_q[IDX_W-1:0]];
    end
    if (cmd_i.emit || cmd_i.pop) begin
      slot_q    <= slot_d;
      stat_q    <= stat_d;
      cnt_out_q <= count_d;
    end
  end

  assign result_valid_o  = valid_q;
  assign slot_index_o    = slot_q;
  assign result_status_o = stat_q;
  assign free_count_o    = cnt_out_q;

endmodule

@@ rtl/index_free_list_allocator.sv @@
// Top level of the index free-list allocator.
//
// Hands out slot indexes 0..255 from a linked free list and takes them back.
// A request beat is taken when start is high and busy is low. Free, clear and
// no-op requests end in the cycle they are taken, as does an allocate from an
// empty list; other allocates also pass through the pop state, since the head
// slot's link comes out of a RAM with a registered read port, and busy is high
// in that state. The result beat shows on the result ports for exactly one
// cycle, marked by result_valid_o, in the cycle after the request ends; the
// receiver cannot stall it. Clear rechains all slots at once, with no sweep.
// An empty allocate answers status 1 and slot 0. A double free is not detected.
module index_free_list_allocator import ifla_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic [1:0]       kind_i,
  input  logic [IDX_W-1:0] entry_index_i,
  output logic             busy,
  output logic             result_valid_o,
  output logic [IDX_W-1:0] slot_index_o,
  output logic             status_o,
  output logic [CNT_W-1:0] free_count_o
);

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;
  kind_e      kind;

  assign kind = kind_e'(kind_i);

  ifla_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .kind_i   (kind),
    .status_i (dp_status),
    .busy_o   (busy),
    .cmd_o    (cmd)
  );

  ifla_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .entry_index_i   (entry_index_i),
    .status_o        (dp_status),
    .result_valid_o  (result_valid_o),
    .slot_index_o    (slot_index_o),
    .result_status_o (status_o),
    .free_count_o    (free_count_o)
  );

endmodule
